/* rtl/eptp_pkg.sv */
package eptp_pkg;

    localparam int unsigned ROW_W = 16;
    localparam int unsigned BND_W = 17;
    localparam int unsigned IDX_W = 2;

    localparam logic [IDX_W-1:0] CFG_MATRIX_ORDER = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TILE_SIZE    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TILE_COUNT   = 2'd2;

    localparam logic [ROW_W-1:0] RST_MATRIX_ORDER = 16'd1;
    localparam logic [ROW_W-1:0] RST_TILE_SIZE    = 16'd64;
    localparam logic [ROW_W-1:0] RST_TILE_COUNT   = 16'd1;

    typedef struct packed {
        logic [ROW_W-1:0] tile_index;
        logic [ROW_W-1:0] start_row;
        logic             shifted;
        logic             is_pad;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] index;
        logic [ROW_W-1:0] data;
    } t_cfg_write;

endpackage

/* rtl/eptp_in_reg.sv */
module eptp_in_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_is_complex,
    input  logic i_advance,
    output logic o_valid,
    output logic o_is_complex
);
    import eptp_pkg::*;

    logic r_valid;
    logic r_is_complex;
    logic n_valid;
    logic w_accept;

    // slot frees up in the same cycle the stage behind takes the request
    assign o_in_ready = !r_valid || i_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_complex <= i_is_complex;
        end
    end

    assign o_valid      = r_valid;
    assign o_is_complex = r_is_complex;

endmodule

/* rtl/eptp_core.sv */
module eptp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  eptp_pkg::t_cfg_write i_cfg,
    input  logic                 i_advance,
    input  logic                 i_is_complex,
    output logic                 o_emit,
    output eptp_pkg::t_result    o_result
);
    import eptp_pkg::*;

    logic [ROW_W-1:0] r_matrix_order;
    logic [ROW_W-1:0] r_tile_size;
    logic [ROW_W-1:0] r_tile_count;

    logic [ROW_W-1:0] r_row_counter;
    logic [ROW_W-1:0] r_current_tile;
    logic [BND_W-1:0] r_next_boundary;
    logic             r_parity;
    logic             r_skip;

    logic [ROW_W-1:0] w_order;
    logic             w_parity;
    logic [BND_W-1:0] w_cnt;
    logic             w_last;
    logic             w_more_tiles;
    logic             w_boundary;
    logic [BND_W:0]   w_start_raw;
    logic [ROW_W-1:0] w_start;
    logic             w_cfg_hit;
    logic [ROW_W-1:0] w_ts_after;

    assign w_order      = (r_matrix_order == '0) ? ROW_W'(1) : r_matrix_order;
    assign w_parity     = r_skip ? r_parity : (r_parity ^ i_is_complex);
    assign w_cnt        = {1'b0, r_row_counter} + BND_W'(1);
    assign w_last       = w_cnt >= {1'b0, w_order};
    assign w_more_tiles = ({1'b0, r_current_tile} + BND_W'(1)) < {1'b0, r_tile_count};
    assign w_boundary   = (w_cnt == r_next_boundary) && w_more_tiles;
    assign w_start_raw  = {1'b0, r_next_boundary} + {{BND_W{1'b0}}, w_parity};
    assign w_start      = (w_start_raw > {2'b00, w_order}) ? w_order
                                                           : w_start_raw[ROW_W-1:0];

    always_comb begin
        o_emit   = 1'b0;
        o_result = '0;
        if (w_last) begin
            o_emit              = 1'b1;
            o_result.tile_index = r_tile_count;
            o_result.start_row  = w_order;
            o_result.is_pad     = 1'b1;
        end else if (w_boundary) begin
            o_emit              = 1'b1;
            o_result.tile_index = r_current_tile + ROW_W'(1);
            o_result.start_row  = w_start;
            o_result.shifted    = w_parity;
        end
    end

    assign w_cfg_hit  = i_cfg.we && (i_cfg.index == CFG_MATRIX_ORDER
                                     || i_cfg.index == CFG_TILE_SIZE
                                     || i_cfg.index == CFG_TILE_COUNT);
    assign w_ts_after = (i_cfg.index == CFG_TILE_SIZE) ? i_cfg.data : r_tile_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_order <= RST_MATRIX_ORDER;
            r_tile_size    <= RST_TILE_SIZE;
            r_tile_count   <= RST_TILE_COUNT;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_MATRIX_ORDER: r_matrix_order <= i_cfg.data;
                CFG_TILE_SIZE:    r_tile_size    <= i_cfg.data;
                CFG_TILE_COUNT:   r_tile_count   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_counter   <= '0;
            r_current_tile  <= '0;
            r_next_boundary <= {1'b0, RST_TILE_SIZE};
            r_parity        <= 1'b0;
            r_skip          <= 1'b0;
        end else if (w_cfg_hit) begin
            r_row_counter   <= '0;
            r_current_tile  <= '0;
            r_next_boundary <= {1'b0, w_ts_after};
            r_parity        <= 1'b0;
            r_skip          <= 1'b0;
        end else if (i_advance) begin
            if (w_last) begin
                // matrix done, start over for the next one
                r_row_counter   <= '0;
                r_current_tile  <= '0;
                r_next_boundary <= {1'b0, r_tile_size};
                r_parity        <= 1'b0;
                r_skip          <= 1'b0;
            end else if (w_boundary) begin
                r_row_counter   <= w_cnt[ROW_W-1:0];
                r_current_tile  <= r_current_tile + ROW_W'(1);
                r_next_boundary <= r_next_boundary + {1'b0, r_tile_size};
                r_parity        <= 1'b0;
                // boundary row of a shifted tile is not counted
                r_skip          <= w_parity;
            end else begin
                r_row_counter   <= w_cnt[ROW_W-1:0];
                r_parity        <= w_parity;
                r_skip          <= 1'b0;
            end
        end
    end

endmodule

/* rtl/eptp_out_reg.sv */
module eptp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_emit,
    input  eptp_pkg::t_result i_result,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output eptp_pkg::t_result o_result
);
    import eptp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_advance) begin
            n_valid = i_emit;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

/* rtl/eigen_pair_tile_partitioner_top.sv */
// path: an accepted request waits in the input register; its result is captured in the result register as it advances
// throughput: one request per cycle; a result register and an input register keep both
// sides moving, the flow stalls only while a result waits on o_out_valid without i_out_ready
// reset: synchronous, active low; stream state cleared, matrix_order 1, tile_size 64,
// tile_count 1; any write to a mapped register restarts the stream
module eigen_pair_tile_partitioner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_is_complex,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_tile_index,
    output logic [15:0] o_start_row,
    output logic        o_shifted,
    output logic        o_is_pad,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import eptp_pkg::*;

    logic       w_stage_valid;
    logic       w_stage_complex;
    logic       w_advance;
    logic       w_emit;
    t_result    w_core_result;
    t_result    w_out_result;
    t_cfg_write w_cfg;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // the staged request moves on when the result slot is empty or being drained
    assign w_advance = w_stage_valid && (!o_out_valid || i_out_ready);

    eptp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_is_complex (i_is_complex),
        .i_advance    (w_advance),
        .o_valid      (w_stage_valid),
        .o_is_complex (w_stage_complex)
    );

    eptp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_advance    (w_advance),
        .i_is_complex (w_stage_complex),
        .o_emit       (w_emit),
        .o_result     (w_core_result)
    );

    eptp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_emit      (w_emit),
        .i_result    (w_core_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result)
    );

    assign o_tile_index = w_out_result.tile_index;
    assign o_start_row  = w_out_result.start_row;
    assign o_shifted    = w_out_result.shifted;
    assign o_is_pad     = w_out_result.is_pad;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage_valid && !w_advance |=> w_stage_valid)
        else $error("staged request dropped while stalled");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_pad_unshifted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_pad |-> !o_shifted && o_start_row != 16'd0)
        else $error("pad entry malformed");

    a_tile_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_pad |-> o_tile_index != 16'd0)
        else $error("tile boundary reported for tile zero");
`endif

endmodule

/* sim/tb_eigen_pair_tile_partitioner_top.sv */
`timescale 1ns / 100ps

module tb_eigen_pair_tile_partitioner_top;
    import eptp_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PART_ITEMS = 377;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 60;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] data;
        bit               flag;
        bit               typed;
        t_result          want;
    } t_stim_row;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             is_complex = 1'b0;
    logic             out_ready = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [15:0]      o_tile_index;
    logic [15:0]      o_start_row;
    logic             o_shifted;
    logic             o_is_pad;

    // predictor copy of the registers and stream state
    logic [ROW_W-1:0] order_reg;
    logic [ROW_W-1:0] tsize_reg;
    logic [ROW_W-1:0] tiles_reg;
    int unsigned      rows_done;
    int unsigned      tiles_done;
    logic [BND_W-1:0] next_bnd;
    bit               parity;
    bit               skip_row;

    t_result          tile_start_q[$];
    t_stim_row        directed_rows[$];
    int               mismatch_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_reqs = 0;
    int               hold_served = 0;
    int               hold_left = 0;
    bit               pair_open = 1'b0;

    eigen_pair_tile_partitioner_top DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_is_complex (is_complex),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_tile_index (o_tile_index),
        .o_start_row  (o_start_row),
        .o_shifted    (o_shifted),
        .o_is_pad     (o_is_pad),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void restart_stream();
        rows_done  = 0;
        tiles_done = 0;
        next_bnd   = BND_W'(tsize_reg);
        parity     = 1'b0;
        skip_row   = 1'b0;
    endfunction

    function automatic void apply_cfg(input logic [IDX_W-1:0] idx,
                                      input logic [ROW_W-1:0] data);
        case (idx)
            CFG_MATRIX_ORDER: order_reg = data;
            CFG_TILE_SIZE:    tsize_reg = data;
            CFG_TILE_COUNT:   tiles_reg = data;
            default:          return;
        endcase
        restart_stream();
    endfunction

    function automatic bit predict_row(input bit flag, output t_result r);
        int unsigned ord;
        int unsigned cnt;
        int unsigned start;
        bit          odd;
        ord = (order_reg == 0) ? 1 : order_reg;
        r = '0;
        if (skip_row)
            skip_row = 1'b0;
        else
            parity ^= flag;
        cnt = rows_done + 1;
        if (cnt >= ord) begin
            r.tile_index = tiles_reg;
            r.start_row  = ROW_W'(ord);
            r.is_pad     = 1'b1;
            restart_stream();
            return 1'b1;
        end
        rows_done = cnt;
        if (cnt == next_bnd && tiles_done + 1 < tiles_reg) begin
            odd   = parity;
            start = next_bnd + odd;
            if (start > ord)
                start = ord;
            r.tile_index = ROW_W'(tiles_done + 1);
            r.start_row  = ROW_W'(start);
            r.shifted    = odd;
            tiles_done   = (tiles_done + 1) & 16'hFFFF;
            next_bnd     = next_bnd + BND_W'(tsize_reg);
            parity       = 1'b0;
            skip_row     = odd;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // mostly whole complex pairs, otherwise noise
    function automatic bit next_flag(input bit tidy);
        if (!tidy)
            return 1'($urandom_range(0, 1));
        if (pair_open) begin
            pair_open = 1'b0;
            return 1'b1;
        end
        if ($urandom_range(0, 2) == 0) begin
            pair_open = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tile_start_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_cfg(idx, data);
    endtask

    task automatic reconfigure(input logic [ROW_W-1:0] ord, input logic [ROW_W-1:0] tsz,
                               input logic [ROW_W-1:0] cnt);
        stop_sending();
        wait_idle();
        write_reg(CFG_MATRIX_ORDER, ord);
        write_reg(CFG_TILE_SIZE, tsz);
        write_reg(CFG_TILE_COUNT, cnt);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(input bit flag, input bit typed, input t_result want);
        int      gap;
        t_result r;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        is_complex <= flag;
        @(posedge clk);
        while (!o_in_ready)
            @(posedge clk);
        if (predict_row(flag, r) || typed)
            tile_start_q.push_back(typed ? want : r);
    endtask

    task automatic run_phase(input logic [ROW_W-1:0] ord, input logic [ROW_W-1:0] tsz,
                             input logic [ROW_W-1:0] cnt, input int n,
                             input int hold_at, input int pause_at);
        bit tidy;
        int k;
        reconfigure(ord, tsz, cnt);
        tidy = ($urandom_range(0, 4) != 0);
        pair_open = 1'b0;
        for (k = 0; k < n; k++) begin
            if (k == hold_at)
                hold_reqs <= hold_reqs + 1;
            if (k == pause_at) begin
                stop_sending();
                do @(posedge clk); while (tile_start_q.size() != 0);
            end
            send_item(next_flag(tidy), 1'b0, '0);
        end
    endtask

    task automatic add_cfg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        t_stim_row row;
        row = '{kind: ROW_CFG, idx: idx, data: data, flag: 1'b0, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_item(input bit flag);
        t_stim_row row;
        row = '{kind: ROW_ITEM, idx: '0, data: '0, flag: flag, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_pad(input bit flag, input logic [ROW_W-1:0] tile,
                           input logic [ROW_W-1:0] start);
        t_stim_row row;
        row = '{kind: ROW_ITEM, idx: '0, data: '0, flag: flag, typed: 1'b1, want: '0};
        row.want.tile_index = tile;
        row.want.start_row  = start;
        row.want.is_pad     = 1'b1;
        directed_rows.push_back(row);
    endtask

    // receiver: random stalls plus a requested long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (tile_start_q.size() == 0) begin
                $error("unexpected result tile_index %0d start_row %0d",
                       o_tile_index, o_start_row);
                mismatch_count++;
            end else begin
                want = tile_start_q.pop_front();
                if (o_tile_index !== want.tile_index) begin
                    $error("tile_index expected %0d got %0d", want.tile_index, o_tile_index);
                    mismatch_count++;
                end
                if (o_start_row !== want.start_row) begin
                    $error("start_row expected %0d got %0d", want.start_row, o_start_row);
                    mismatch_count++;
                end
                if (o_shifted !== want.shifted) begin
                    $error("shifted expected %0d got %0d", want.shifted, o_shifted);
                    mismatch_count++;
                end
                if (o_is_pad !== want.is_pad) begin
                    $error("is_pad expected %0d got %0d", want.is_pad, o_is_pad);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_eigen_pair_tile_partitioner_top NOT OK");
        $finish;
    end

    initial begin
        logic [ROW_W-1:0] ord;
        logic [ROW_W-1:0] tsz;
        logic [ROW_W-1:0] cnt;
        int               ceil_tiles;
        int               n;
        int               done;
        int               hold_at;
        int               pause_at;
        int               waited;

        order_reg = RST_MATRIX_ORDER;
        tsize_reg = RST_TILE_SIZE;
        tiles_reg = RST_TILE_COUNT;
        restart_stream();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset every row is a one-row matrix
        add_pad(1'b0, 16'd1, 16'd1);
        add_pad(1'b1, 16'd1, 16'd1);
        // zero order behaves as order one
        add_cfg(CFG_MATRIX_ORDER, 16'd0);
        add_pad(1'b1, 16'd1, 16'd1);
        add_cfg(CFG_TILE_COUNT, 16'd0);
        add_pad(1'b0, 16'd0, 16'd1);
        // shifted starts, clamp at the order, unmapped index leaves the stream alone
        add_cfg(CFG_MATRIX_ORDER, 16'd10);
        add_cfg(CFG_TILE_SIZE, 16'd3);
        add_cfg(CFG_TILE_COUNT, 16'd4);
        add_item(1'b1);
        add_item(1'b0);
        add_item(1'b1);
        add_item(1'b1);
        add_item(1'b0);
        add_cfg(CFG_UNUSED, 16'hFFFF);
        add_item(1'b0);
        add_item(1'b1);
        add_item(1'b1);
        add_item(1'b0);
        add_item(1'b1);
        // too few tiles, odd parity on the last tile
        add_cfg(CFG_MATRIX_ORDER, 16'd5);
        add_cfg(CFG_TILE_SIZE, 16'd2);
        add_cfg(CFG_TILE_COUNT, 16'd2);
        add_item(1'b1);
        add_item(1'b0);
        add_item(1'b1);
        add_item(1'b1);
        add_item(1'b1);
        // zero tile size: only the pad entry
        add_cfg(CFG_TILE_SIZE, 16'd0);
        add_cfg(CFG_MATRIX_ORDER, 16'd3);
        add_cfg(CFG_TILE_COUNT, 16'hFFFF);
        add_item(1'b1);
        add_item(1'b1);
        add_pad(1'b1, 16'hFFFF, 16'd3);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                stop_sending();
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
                cfg_we <= 1'b0;
            end else begin
                send_item(directed_rows[i].flag, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        for (int part = 0; part < 3; part++) begin
            case (part)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct <= 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct <= 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            done = 0;
            while (done < PART_ITEMS) begin
                hold_at  = -1;
                pause_at = -1;
                n = $urandom_range(20, 90);
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 4))
                        0: begin ord = 16'hFFFF; tsz = 16'hFFFF; cnt = 16'hFFFF; end
                        1: begin ord = 16'hFFFF; tsz = 16'd2;    cnt = 16'hFFFF; end
                        2: begin ord = 16'd2;    tsz = 16'hFFFF; cnt = 16'd1;    end
                        3: begin ord = 16'd0;    tsz = 16'd1;    cnt = 16'd0;    end
                        default: begin ord = 16'd37; tsz = 16'd1; cnt = 16'd37; end
                    endcase
                end else begin
                    ord = ROW_W'($urandom_range(1, 48));
                    tsz = ROW_W'($urandom_range(1, 9));
                    ceil_tiles = (ord + tsz - 1) / tsz;
                    if ($urandom_range(0, 3) != 0)
                        cnt = ROW_W'(ceil_tiles);
                    else
                        cnt = ROW_W'($urandom_range(0, ceil_tiles + 2));
                end
                if (part == 2 && done == 0) begin
                    // receiver stalls long enough to back up the input side
                    ord = 16'd40;
                    tsz = 16'd2;
                    cnt = 16'd20;
                    n = 60;
                    hold_at = 5;
                    pause_at = 40;
                end
                if (n > PART_ITEMS - done)
                    n = PART_ITEMS - done;
                run_phase(ord, tsz, cnt, n, hold_at, pause_at);
                done += n;
            end
        end

        stop_sending();
        waited = 0;
        while (tile_start_q.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (tile_start_q.size() != 0) begin
            $error("%0d expected results never arrived", tile_start_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_eigen_pair_tile_partitioner_top OK");
        else
            $display("tb_eigen_pair_tile_partitioner_top NOT OK");
        $finish;
    end

endmodule
